/* hw/rtl/rcsc_pkg.sv */
// Shared types and constants for the RC stick conditioner.
// Used by every module under hw/rtl; depends on nothing else.
package rcsc_pkg;

    // Field widths
    localparam int PULSE_W = 11;
    localparam int EXPO_W  = 9;
    localparam int CMD_W   = 10;
    localparam int MODE_W  = 2;

    // Number of register stages in the datapath
    localparam int NUM_STAGES = 8;

    // APB register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_CURVE_BLEND      = 2'd0,
        REG_THROTTLE_FLOOR   = 2'd1,
        REG_THROTTLE_CEILING = 2'd2,
        REG_STICK_CENTER     = 2'd3
    } reg_index_t;

    // Register reset values
    localparam logic [EXPO_W-1:0]  EXPO_RESET     = 9'd0;
    localparam logic [PULSE_W-1:0] FLOOR_RESET    = 11'd1000;
    localparam logic [PULSE_W-1:0] CEILING_RESET  = 11'd2000;
    localparam logic [PULSE_W-1:0] CENTER_RESET   = 11'd1500;

    // Flight mode codes and the aux thresholds that select them
    typedef enum logic [MODE_W-1:0] {
        PILOT_RATE      = 2'd0,
        PILOT_ACRO      = 2'd1,
        PILOT_STABILIZE = 2'd2
    } pilot_mode_t;

    localparam logic [PULSE_W-1:0] MODE_LOW_EDGE  = 11'd1300;
    localparam logic [PULSE_W-1:0] MODE_HIGH_EDGE = 11'd1700;

    // Expo curve constants: q = N / (256 * 250000), N / 2^12 / 15625
    localparam logic signed [9:0]  EXPO_ONE     = 10'sd256;
    localparam logic signed [18:0] EXPO_SCALE   = 19'sd250000;
    localparam logic [42:0]        SAT_LEVEL    = 43'd32000000000;
    localparam logic [13:0]        DIV_ODD      = 14'd15625;
    localparam logic [18:0]        DIV_RECIP    = 19'd274877;
    localparam logic [8:0]         CMD_LIMIT    = 9'd500;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [EXPO_W-1:0]  curve_blend;
        logic [PULSE_W-1:0] throttle_floor;
        logic [PULSE_W-1:0] throttle_ceiling;
        logic [PULSE_W-1:0] stick_center;
    } cfg_t;

endpackage

/* hw/rtl/rcsc_cfg_regs.sv */
// APB configuration registers of the RC stick conditioner.
// Depends on rcsc_pkg for the register map and the cfg_t struct.
module rcsc_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcsc_pkg::DATA_W-1:0]   pwdata,
    output logic [rcsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rcsc_pkg::cfg_t                cfg
);

    rcsc_pkg::cfg_t     cfg_reg;
    rcsc_pkg::cfg_t     cfg_next;
    rcsc_pkg::reg_index_t index;
    logic               wr_en;

    assign pready = 1'b1;
    assign index  = rcsc_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                rcsc_pkg::REG_CURVE_BLEND:
                    cfg_next.curve_blend = pwdata[rcsc_pkg::EXPO_W-1:0];
                rcsc_pkg::REG_THROTTLE_FLOOR:
                    cfg_next.throttle_floor = pwdata[rcsc_pkg::PULSE_W-1:0];
                rcsc_pkg::REG_THROTTLE_CEILING:
                    cfg_next.throttle_ceiling = pwdata[rcsc_pkg::PULSE_W-1:0];
                rcsc_pkg::REG_STICK_CENTER:
                    cfg_next.stick_center = pwdata[rcsc_pkg::PULSE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.curve_blend      <= rcsc_pkg::EXPO_RESET;
            cfg_reg.throttle_floor   <= rcsc_pkg::FLOOR_RESET;
            cfg_reg.throttle_ceiling <= rcsc_pkg::CEILING_RESET;
            cfg_reg.stick_center     <= rcsc_pkg::CENTER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back multiplexer
    always_comb
    begin
        case (index)
            rcsc_pkg::REG_CURVE_BLEND:
                prdata = {23'd0, cfg_reg.curve_blend};
            rcsc_pkg::REG_THROTTLE_FLOOR:
                prdata = {21'd0, cfg_reg.throttle_floor};
            rcsc_pkg::REG_THROTTLE_CEILING:
                prdata = {21'd0, cfg_reg.throttle_ceiling};
            rcsc_pkg::REG_STICK_CENTER:
                prdata = {21'd0, cfg_reg.stick_center};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/rcsc_pipe_ctrl.sv */
// Valid and stall control for the stage pipeline of the RC stick conditioner.
// Depends on rcsc_pkg for the stage count.
module rcsc_pipe_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rcsc_pkg::NUM_STAGES-1:0]   adv
);

    localparam int NS = rcsc_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;

    // A stage loads when it is empty or when its contents move on.
    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    // Valid bits follow the data through the stages
    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NS-1];

    // The number of items held changes only by what enters and what leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rst_n && $past(rst_n)) |->
        ($countones(valid_reg) == $countones($past(valid_reg))
            + int'($past(in_valid && in_ready))
            - int'($past(out_valid && out_ready))))
        else $error("pipeline item count not conserved");

    // Input back-pressure only when every stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    // A held stage keeps its item while the next stage cannot take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !adv[1]) |=> valid_reg[0])
        else $error("first stage lost an item under stall");

endmodule

/* hw/rtl/rcsc_axis_lane.sv */
// One stick axis of the RC stick conditioner: centring and the cubic expo
// curve over eight register stages. Depends on rcsc_pkg for constants.
module rcsc_axis_lane
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [rcsc_pkg::NUM_STAGES-1:0]       adv,
    input  logic                                  out_valid,
    input  logic [rcsc_pkg::PULSE_W-1:0]          pulse,
    input  rcsc_pkg::cfg_t                        cfg,
    output logic signed [rcsc_pkg::CMD_W-1:0]     cmd
);

    // Stage 1: centred stick and linear weight
    logic signed [11:0] x1_reg;
    logic signed [11:0] x1_next;
    logic signed [9:0]  w1_reg;
    logic signed [9:0]  w1_next;

    // Stage 2: square and linear product
    logic signed [23:0] x2_full;
    logic signed [21:0] xw_full;
    logic signed [22:0] x2_reg;
    logic signed [19:0] xw2_reg;
    logic signed [11:0] x_s2_reg;

    // Stage 3: cube and scaled linear term
    logic signed [34:0] x3_full;
    logic signed [38:0] lin_full;
    logic signed [33:0] x3_reg;
    logic signed [37:0] lin3_reg;

    // Stage 4: weighted cube
    logic signed [43:0] cub_full;
    logic signed [42:0] cub4_reg;
    logic signed [37:0] lin4_reg;

    // Stage 5: numerator
    logic signed [43:0] num_next;
    logic signed [43:0] num5_reg;

    // Stage 6: magnitude, sign and saturation
    logic [43:0]        mag_full;
    logic [42:0]        mag_abs;
    logic               neg6_reg;
    logic               sat6_reg;
    logic [22:0]        m6_reg;

    // Stage 7: reciprocal estimate of the quotient
    logic [41:0]        est_full;
    logic [8:0]         qa7_reg;
    logic [22:0]        m7_reg;
    logic               neg7_reg;
    logic               sat7_reg;

    // Stage 8: correction, saturation and sign
    logic [22:0]        qprod;
    logic [23:0]        rem;
    logic [8:0]         quo;
    logic [8:0]         mag_out;
    logic signed [9:0]  cmd_next;
    logic signed [9:0]  cmd_reg;

    assign x1_next = $signed({1'b0, pulse}) - $signed({1'b0, cfg.stick_center});
    assign w1_next = rcsc_pkg::EXPO_ONE - $signed({1'b0, cfg.curve_blend});

    assign x2_full  = 24'(x1_reg) * 24'(x1_reg);
    assign xw_full  = 22'(x1_reg) * 22'(w1_reg);
    assign x3_full  = 35'(x2_reg) * 35'(x_s2_reg);
    assign lin_full = 39'(xw2_reg) * 39'(rcsc_pkg::EXPO_SCALE);
    assign cub_full = 44'(x3_reg) * 44'($signed({1'b0, cfg.curve_blend}));
    assign num_next = 44'(lin4_reg) + 44'(cub4_reg);

    // The low twelve bits of the divisor are a shift; the odd part is 15625.
    assign mag_full = num5_reg[43] ? (-num5_reg) : num5_reg;
    assign mag_abs  = mag_full[42:0];

    assign est_full = 42'(m6_reg) * 42'(rcsc_pkg::DIV_RECIP);

    // The estimate is the quotient or one short of it.
    assign qprod    = 23'(qa7_reg) * 23'(rcsc_pkg::DIV_ODD);
    assign rem      = {1'b0, m7_reg} - {1'b0, qprod};
    assign quo      = (rem >= {10'd0, rcsc_pkg::DIV_ODD}) ? (qa7_reg + 9'd1) : qa7_reg;
    assign mag_out  = sat7_reg ? rcsc_pkg::CMD_LIMIT : quo;
    assign cmd_next = neg7_reg ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});

    // Datapath registers, each stage loading when the control lets it move
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x1_reg <= x1_next;
            w1_reg <= w1_next;
        end
        if (adv[1])
        begin
            x2_reg   <= x2_full[22:0];
            xw2_reg  <= xw_full[19:0];
            x_s2_reg <= x1_reg;
        end
        if (adv[2])
        begin
            x3_reg   <= x3_full[33:0];
            lin3_reg <= lin_full[37:0];
        end
        if (adv[3])
        begin
            cub4_reg <= cub_full[42:0];
            lin4_reg <= lin3_reg;
        end
        if (adv[4])
        begin
            num5_reg <= num_next;
        end
        if (adv[5])
        begin
            neg6_reg <= num5_reg[43];
            sat6_reg <= (mag_abs >= rcsc_pkg::SAT_LEVEL);
            m6_reg   <= mag_abs[34:12];
        end
        if (adv[6])
        begin
            qa7_reg  <= est_full[40:32];
            m7_reg   <= m6_reg;
            neg7_reg <= neg6_reg;
            sat7_reg <= sat6_reg;
        end
        if (adv[7])
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd = cmd_reg;

    // A delivered command never leaves the saturation range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cmd_reg <= 10'sd500 && cmd_reg >= -10'sd500))
        else $error("axis command outside the saturation range");

endmodule

/* hw/rtl/rc_stick_conditioner.sv */
// RC stick conditioner top level: stream ports, APB registers and datapath.
// Depends on rcsc_pkg, rcsc_cfg_regs, rcsc_pipe_ctrl and rcsc_axis_lane.
//
// The block takes one radio frame of five pulse widths per item and returns
// one item of conditioned commands. Throttle is clamped to the floor and
// ceiling registers, roll, pitch and yaw are centred and passed through the
// cubic expo curve with saturation to plus or minus 500, and the aux pulse
// selects the flight mode. An item accepted at the input passes through the
// eight register stages of the axis datapath (centring, square, cube,
// weighting, sum, magnitude, reciprocal divide and correction) into the
// output register and can leave from there; a new item is accepted in every
// cycle, so throughput is one item per cycle while the output side takes
// items, and a stalled output only holds the input once every stage is
// full. Registers should be written only while no item is in flight.
module rc_stick_conditioner
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Input frame
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [10:0] throttle_pulse, [21:11] roll_pulse, [32:22] pitch_pulse,
    // [43:33] yaw_pulse, [54:44] aux_pulse, [55] zero
    input  logic [55:0]                 s_axis_tdata,
    // Conditioned commands
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [10:0] throttle_command, [20:11] roll_command, [30:21] pitch_command,
    // [40:31] yaw_command, [42:41] pilot_mode, [47:43] zero
    output logic [47:0]                 m_axis_tdata,
    // Configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int NS = rcsc_pkg::NUM_STAGES;

    rcsc_pkg::cfg_t                 cfg;
    logic [NS-1:0]                  adv;

    logic [rcsc_pkg::PULSE_W-1:0]   throttle_pulse;
    logic [rcsc_pkg::PULSE_W-1:0]   roll_pulse;
    logic [rcsc_pkg::PULSE_W-1:0]   pitch_pulse;
    logic [rcsc_pkg::PULSE_W-1:0]   yaw_pulse;
    logic [rcsc_pkg::PULSE_W-1:0]   aux_pulse;

    logic [rcsc_pkg::PULSE_W-1:0]   throttle_next;
    rcsc_pkg::pilot_mode_t          mode_next;

    logic [rcsc_pkg::PULSE_W-1:0]   throttle_reg [NS];
    rcsc_pkg::pilot_mode_t          mode_reg [NS];

    logic signed [rcsc_pkg::CMD_W-1:0] roll_command;
    logic signed [rcsc_pkg::CMD_W-1:0] pitch_command;
    logic signed [rcsc_pkg::CMD_W-1:0] yaw_command;

    assign throttle_pulse = s_axis_tdata[10:0];
    assign roll_pulse     = s_axis_tdata[21:11];
    assign pitch_pulse    = s_axis_tdata[32:22];
    assign yaw_pulse      = s_axis_tdata[43:33];
    assign aux_pulse      = s_axis_tdata[54:44];

    rcsc_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcsc_pipe_ctrl u_pipe_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .adv       (adv)
    );

    rcsc_axis_lane u_roll_lane
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .out_valid (m_axis_tvalid),
        .pulse     (roll_pulse),
        .cfg       (cfg),
        .cmd       (roll_command)
    );

    rcsc_axis_lane u_pitch_lane
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .out_valid (m_axis_tvalid),
        .pulse     (pitch_pulse),
        .cfg       (cfg),
        .cmd       (pitch_command)
    );

    rcsc_axis_lane u_yaw_lane
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .out_valid (m_axis_tvalid),
        .pulse     (yaw_pulse),
        .cfg       (cfg),
        .cmd       (yaw_command)
    );

    // Throttle clamp; with the floor above the ceiling, pulses below the floor give the floor, others the ceiling.
    always_comb
    begin
        if (throttle_pulse < cfg.throttle_floor)
        begin
            throttle_next = cfg.throttle_floor;
        end
        else if (throttle_pulse > cfg.throttle_ceiling)
        begin
            throttle_next = cfg.throttle_ceiling;
        end
        else
        begin
            throttle_next = throttle_pulse;
        end
    end

    // Flight mode from the aux pulse
    always_comb
    begin
        if (aux_pulse < rcsc_pkg::MODE_LOW_EDGE)
        begin
            mode_next = rcsc_pkg::PILOT_RATE;
        end
        else if (aux_pulse < rcsc_pkg::MODE_HIGH_EDGE)
        begin
            mode_next = rcsc_pkg::PILOT_ACRO;
        end
        else
        begin
            mode_next = rcsc_pkg::PILOT_STABILIZE;
        end
    end

    // Throttle and mode travel alongside the axis stages.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            throttle_reg[0] <= throttle_next;
            mode_reg[0]     <= mode_next;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (adv[k])
            begin
                throttle_reg[k] <= throttle_reg[k-1];
                mode_reg[k]     <= mode_reg[k-1];
            end
        end
    end

    assign m_axis_tdata = {5'd0, mode_reg[NS-1], yaw_command, pitch_command,
                           roll_command, throttle_reg[NS-1]};

    // A delivered flight mode is always one of the three defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[42:41] != 2'd3))
        else $error("undefined flight mode delivered");

endmodule
